### src/h264fs_pkg.sv
`timescale 1ns / 1ps

package h264fs_pkg;

	// Input transfer: one stream byte
	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} byte_t;

	// Output transfer: one frame descriptor
	typedef struct packed {
		logic [31:0] frame_offset;
		logic [31:0] frame_length;
		logic        key_frame;
		logic [4:0]  slice_nal_type;
		logic        header_error;
	} frame_t;

	// Byte classes assigned by the front end
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_HEADER = 2'd2;

	// Classified byte passed from front end to back end
	typedef struct packed {
		logic [1:0] kind;
		logic       long_start;
		logic [7:0] data;
		logic       eos;
	} item_t;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0] NAL_SLICE     = 5'd1;
	localparam logic [4:0] NAL_IDR       = 5'd5;

	localparam logic [2:0] SLICE_MOD_P_INTRA = 3'd2;
	localparam logic [2:0] SLICE_MOD_I_INTRA = 3'd4;

endpackage

### src/h264fs_front.sv
`timescale 1ns / 1ps

module h264fs_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  h264fs_pkg::byte_t       byte_data,
	input  logic                    take,
	output h264fs_pkg::item_t       item,
	output logic [OFFSET_BITS-1:0]  pos
);

	logic [OFFSET_BITS-1:0] pos_q;
	logic [23:0]            recent_q;
	logic                   hdr_next_q;

	always_comb begin
		item.data       = byte_data.stream_byte;
		item.eos        = byte_data.end_of_stream;
		item.long_start = (recent_q[23:16] == 8'd0);
		if (hdr_next_q) begin
			item.kind = h264fs_pkg::KIND_HEADER;
		end else if (recent_q[15:0] == 16'd0 && byte_data.stream_byte == 8'd1) begin
			item.kind = h264fs_pkg::KIND_START;
		end else begin
			item.kind = h264fs_pkg::KIND_DATA;
		end
	end

	assign pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			recent_q   <= 24'hFFFFFF;
			hdr_next_q <= 1'b0;
		end else if (take) begin
			case (item.kind)
				h264fs_pkg::KIND_START: begin
					recent_q   <= 24'hFFFFFF;
					hdr_next_q <= 1'b1;
				end
				h264fs_pkg::KIND_HEADER: begin
					hdr_next_q <= 1'b0;
				end
				default: begin
					recent_q <= {recent_q[15:0], byte_data.stream_byte};
				end
			endcase
			// End of stream: return to the idle search state
			if (byte_data.end_of_stream) begin
				pos_q      <= '0;
				recent_q   <= 24'hFFFFFF;
				hdr_next_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

### src/h264fs_queue.sv
`timescale 1ns / 1ps

module h264fs_queue #(
	parameter int POS_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  h264fs_pkg::item_t     push_item,
	input  logic [POS_BITS-1:0]   push_pos,
	output logic                  full,
	input  logic                  pop,
	output logic                  valid,
	output h264fs_pkg::item_t     head_item,
	output logic [POS_BITS-1:0]   head_pos
);

	localparam int PW = $clog2(h264fs_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(h264fs_pkg::QUEUE_DEPTH + 1);

	h264fs_pkg::item_t     item_mem [h264fs_pkg::QUEUE_DEPTH];
	logic [POS_BITS-1:0]   pos_mem  [h264fs_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;

	assign full      = (count_q == CW'(h264fs_pkg::QUEUE_DEPTH));
	assign valid     = (count_q != '0);
	assign head_item = item_mem[rd_ptr_q];
	assign head_pos  = pos_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_mem[wr_ptr_q] <= push_item;
			pos_mem[wr_ptr_q]  <= push_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(h264fs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(h264fs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/h264fs_back.sv
`timescale 1ns / 1ps

module h264fs_back #(
	parameter int OFFSET_BITS      = 32,
	parameter int MAX_GOLOMB_ZEROS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  h264fs_pkg::item_t       item,
	input  logic [OFFSET_BITS-1:0]  pos,
	output logic                    pop,
	output logic                    frame_valid,
	input  logic                    frame_stall,
	output h264fs_pkg::frame_t      frame_info
);

	localparam int GW = MAX_GOLOMB_ZEROS + 1;
	localparam int ZW = $clog2(MAX_GOLOMB_ZEROS + 2);

	localparam logic [2:0] PH_SEEK   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_ZEROS  = 3'd2;
	localparam logic [2:0] PH_SUFFIX = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	function automatic logic [2:0] mod5_step(input logic [2:0] m, input logic b);
		logic [3:0] t;
		t = {m, b};
		mod5_step = (t >= 4'd5) ? 3'(t - 4'd5) : t[2:0];
	endfunction

	logic [2:0]             phase_q, ph_n;
	logic [OFFSET_BITS-1:0] nal_start_q, nal_n;
	logic [OFFSET_BITS-1:0] frame_start_q, fs_n;
	logic                   has_q, has_n;
	logic [4:0]             type_q, type_n;
	logic [GW-1:0]          first_mb_q, first_mb_n;
	logic                   key_q, key_n;
	logic [ZW-1:0]          zc_q, zc_n;
	logic [GW-1:0]          val_q, val_n;
	logic [2:0]             mod_q, mod_n;
	logic                   fidx_q, fidx_n;
	logic                   err_q, err_n;
	logic                   out_valid_q;
	h264fs_pkg::frame_t     out_q;

	logic                   emit_mid, emit_eos;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [4:0]             hdr_type;
	logic                   done, derr, keep;
	logic [GW-1:0]          dv;
	logic [2:0]             dmod;
	h264fs_pkg::frame_t     res;

	assign pop         = item_valid && (!out_valid_q || !frame_stall);
	assign frame_valid = out_valid_q;
	assign frame_info  = out_q;

	assign start_pos = pos - (item.long_start ? OFFSET_BITS'(3) : OFFSET_BITS'(2));
	assign hdr_type  = item.data[4:0] & h264fs_pkg::NAL_TYPE_MASK;

	always_comb begin
		ph_n       = phase_q;
		nal_n      = nal_start_q;
		fs_n       = frame_start_q;
		has_n      = has_q;
		type_n     = type_q;
		first_mb_n = first_mb_q;
		key_n      = key_q;
		zc_n       = zc_q;
		val_n      = val_q;
		mod_n      = mod_q;
		fidx_n     = fidx_q;
		err_n      = err_q;
		emit_mid   = 1'b0;
		emit_eos   = 1'b0;
		done       = 1'b0;
		derr       = 1'b0;
		keep       = 1'b0;
		dv         = '0;
		dmod       = '0;

		case (item.kind)
			h264fs_pkg::KIND_START: begin
				if (phase_q == PH_SEEK) begin
					fs_n  = start_pos;
					err_n = 1'b0;
				end
				nal_n  = start_pos;
				fidx_n = 1'b0;
				ph_n   = PH_HEADER;
			end
			h264fs_pkg::KIND_HEADER: begin
				// A NAL of another type closes a frame that already has a slice
				if (has_q && hdr_type != type_q) begin
					emit_mid = 1'b1;
					fs_n     = nal_start_q;
					has_n    = 1'b0;
					err_n    = 1'b0;
				end
				if (has_n || hdr_type == h264fs_pkg::NAL_SLICE
						|| hdr_type == h264fs_pkg::NAL_IDR) begin
					if (!has_n) begin
						type_n = hdr_type;
					end
					fidx_n = 1'b0;
					zc_n   = '0;
					val_n  = '0;
					mod_n  = '0;
					ph_n   = PH_ZEROS;
				end else begin
					ph_n = PH_SKIP;
				end
			end
			default: begin
				// Walk the Exp-Golomb bits of this byte, MSB first
				for (int k = 7; k >= 0; k--) begin
					if (ph_n == PH_ZEROS || ph_n == PH_SUFFIX) begin
						done = 1'b0;
						derr = 1'b0;
						dv   = '0;
						dmod = '0;
						if (ph_n == PH_ZEROS) begin
							if (!item.data[k]) begin
								zc_n = zc_n + 1'b1;
								if (zc_n > ZW'(MAX_GOLOMB_ZEROS)) begin
									done = 1'b1;
									derr = 1'b1;
								end
							end else if (zc_n == '0) begin
								done = 1'b1;
							end else begin
								val_n = GW'(1);
								mod_n = 3'd1;
								ph_n  = PH_SUFFIX;
							end
						end else begin
							val_n = {val_n[GW-2:0], item.data[k]};
							mod_n = mod5_step(mod_n, item.data[k]);
							zc_n  = zc_n - 1'b1;
							if (zc_n == '0) begin
								done = 1'b1;
								dv   = val_n - GW'(1);
								dmod = (mod_n == 3'd0) ? 3'd4 : mod_n - 3'd1;
							end
						end
						if (done) begin
							if (fidx_n) begin
								// coding type of the first slice
								err_n  = err_n | derr;
								key_n  = (type_n == h264fs_pkg::NAL_IDR)
									|| dmod == h264fs_pkg::SLICE_MOD_P_INTRA
									|| dmod == h264fs_pkg::SLICE_MOD_I_INTRA;
								has_n  = 1'b1;
								fidx_n = 1'b0;
								ph_n   = PH_SKIP;
							end else begin
								// first macroblock index of the slice
								keep = 1'b1;
								if (has_n) begin
									if (first_mb_n > dv || (first_mb_n == '0 && dv == '0)) begin
										emit_mid = 1'b1;
										fs_n     = nal_start_q;
										has_n    = 1'b0;
										err_n    = derr;
									end else begin
										err_n = err_n | derr;
										ph_n  = PH_SKIP;
										keep  = 1'b0;
									end
								end else begin
									err_n = err_n | derr;
								end
								if (keep) begin
									first_mb_n = dv;
									if (derr) begin
										key_n  = (type_n == h264fs_pkg::NAL_IDR);
										has_n  = 1'b1;
										fidx_n = 1'b0;
										ph_n   = PH_SKIP;
									end else begin
										fidx_n = 1'b1;
										zc_n   = '0;
										val_n  = '0;
										mod_n  = '0;
										ph_n   = PH_ZEROS;
									end
								end
							end
						end
					end
				end
			end
		endcase

		// Closing frame: registered state at the split point
		res.frame_offset   = 32'(frame_start_q);
		res.frame_length   = 32'(nal_start_q - frame_start_q);
		res.key_frame      = key_q;
		res.slice_nal_type = type_q;
		res.header_error   = err_q;

		if (item.eos) begin
			if (!emit_mid && has_n) begin
				emit_eos           = 1'b1;
				res.frame_offset   = 32'(fs_n);
				res.frame_length   = 32'(pos - fs_n + OFFSET_BITS'(1));
				res.key_frame      = key_n;
				res.slice_nal_type = type_n;
				res.header_error   = err_n;
			end
			ph_n       = PH_SEEK;
			nal_n      = '0;
			fs_n       = '0;
			has_n      = 1'b0;
			type_n     = '0;
			first_mb_n = '0;
			key_n      = 1'b0;
			zc_n       = '0;
			val_n      = '0;
			mod_n      = '0;
			fidx_n     = 1'b0;
			err_n      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SEEK;
			nal_start_q   <= '0;
			frame_start_q <= '0;
			has_q         <= 1'b0;
			type_q        <= '0;
			first_mb_q    <= '0;
			key_q         <= 1'b0;
			zc_q          <= '0;
			val_q         <= '0;
			mod_q         <= '0;
			fidx_q        <= 1'b0;
			err_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q       <= ph_n;
				nal_start_q   <= nal_n;
				frame_start_q <= fs_n;
				has_q         <= has_n;
				type_q        <= type_n;
				first_mb_q    <= first_mb_n;
				key_q         <= key_n;
				zc_q          <= zc_n;
				val_q         <= val_n;
				mod_q         <= mod_n;
				fidx_q        <= fidx_n;
				err_q         <= err_n;
			end
			if (pop && (emit_mid || emit_eos)) begin
				out_valid_q <= 1'b1;
			end else if (!frame_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (emit_mid || emit_eos)) begin
			out_q <= res;
		end
	end

endmodule

### src/h264_annexb_frame_splitter.sv
`timescale 1ns / 1ps

// H.264 Annex B frame splitter. Feed the elementary stream one byte per
// transfer on the byte channel and mark the final byte with end_of_stream;
// each frame found comes out as one transfer on the frame channel carrying
// its byte offset, length, key flag, first-slice NAL type and a header error
// flag. The block takes one byte per clock cycle sustained unless a stall on
// the frame channel holds a pending result. The rate is set by the back end,
// which acts on the byte the front end classified and runs the eight
// Exp-Golomb bit steps of that byte together. A result is registered: the
// byte that closes the frame lands in the two-entry queue at its transfer,
// and the back end loads the output register when it pops that byte. A stall
// on the frame channel holds the back end; the queue absorbs up to two bytes
// before the byte channel stalls. Emulation-prevention bytes are left in the
// stream, and after the final byte the parsing state is back at reset values.
module h264_annexb_frame_splitter #(
	parameter int OFFSET_BITS      = 32,
	parameter int MAX_GOLOMB_ZEROS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  h264fs_pkg::byte_t   byte_data,
	output logic                frame_valid,
	input  logic                frame_stall,
	output h264fs_pkg::frame_t  frame_info
);

	logic                   q_full;
	logic                   q_push;
	logic                   q_valid;
	logic                   q_pop;
	h264fs_pkg::item_t      front_item;
	h264fs_pkg::item_t      head_item;
	logic [OFFSET_BITS-1:0] front_pos;
	logic [OFFSET_BITS-1:0] head_pos;

	// Hold the byte channel only while the queue is full
	assign byte_stall = q_full;
	assign q_push     = byte_valid && !q_full;

	// Front end: track position, find start codes, tag header bytes
	h264fs_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_data(byte_data),
		.take     (q_push),
		.item     (front_item),
		.pos      (front_pos)
	);

	// Decouple classification from frame tracking
	h264fs_queue #(
		.POS_BITS(OFFSET_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(front_item),
		.push_pos (front_pos),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_item(head_item),
		.head_pos (head_pos)
	);

	// Back end: decode slice headers, cut frames, drive the result register
	h264fs_back #(
		.OFFSET_BITS     (OFFSET_BITS),
		.MAX_GOLOMB_ZEROS(MAX_GOLOMB_ZEROS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (head_item),
		.pos        (head_pos),
		.pop        (q_pop),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_info (frame_info)
	);

endmodule

### src/h264fs_checker.sv
`timescale 1ns / 1ps

module h264fs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input h264fs_pkg::byte_t   byte_data,
	input logic                frame_valid,
	input logic                frame_stall,
	input h264fs_pkg::frame_t  frame_info
);

	// Hold a stalled byte
	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("byte transfer changed while stalled");

	// Hold a stalled result
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid)
		else $error("frame_valid dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> $stable(frame_info))
		else $error("frame_info changed while stalled");

	// Every frame is anchored on a coded slice
	a_slice_type: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> frame_info.slice_nal_type == h264fs_pkg::NAL_SLICE
			|| frame_info.slice_nal_type == h264fs_pkg::NAL_IDR)
		else $error("frame reported without a slice NAL type");

	// IDR frames are always key frames
	a_idr_key: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_info.slice_nal_type == h264fs_pkg::NAL_IDR
			|-> frame_info.key_frame)
		else $error("IDR frame not flagged as key frame");

endmodule

bind h264_annexb_frame_splitter h264fs_checker u_checker (.*);
